// ----- rtl/cmzp_pkg.sv -----
package cmzp_pkg;

   // Field widths of the request and response beats
   localparam int MODE_W    = 2;
   localparam int FILTER_W  = 4;
   localparam int CHANNEL_W = 4;
   localparam int COORD_W   = 6;
   localparam int VALUE_W   = 16;

   // Register widths and port widths of the CSR write port
   localparam int DIM_REG_W   = 7;
   localparam int CNT_REG_W   = 5;
   localparam int SMALL_REG_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Register reset values
   localparam logic [DIM_REG_W-1:0]   IMAGE_DIM_RST    = 7'd64;
   localparam logic [CNT_REG_W-1:0]   IN_CHANNELS_RST  = 5'd1;
   localparam logic [CNT_REG_W-1:0]   FILTER_COUNT_RST = 5'd1;
   localparam logic [SMALL_REG_W-1:0] PAD_WIDTH_RST    = 2'd1;
   localparam logic [SMALL_REG_W-1:0] KERNEL_SIZE_RST  = 2'd3;

   // Largest pad the datapath honors
   localparam logic [SMALL_REG_W-1:0] PAD_MAX = 2'd2;

   // Cycles between the last tap issue and the accumulator holding it
   localparam int DRAIN_CYCLES = 2;

   // Saturation bounds of a Q8.8 result
   localparam int VALUE_MAX = 32767;
   localparam int VALUE_MIN = -32768;

   typedef enum logic [MODE_W-1:0] {
      MODE_PIXEL   = 2'd0,
      MODE_WEIGHT  = 2'd1,
      MODE_BIAS    = 2'd2,
      MODE_COMPUTE = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_DIM    = 3'd0,
      REG_IN_CHANNELS  = 3'd1,
      REG_FILTER_COUNT = 3'd2,
      REG_PAD_WIDTH    = 3'd3,
      REG_KERNEL_SIZE  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_DRAIN = 2'd2,
      ST_FINAL = 2'd3
   } state_type;

   typedef struct packed {
      logic [DIM_REG_W-1:0]   image_dim;
      logic [CNT_REG_W-1:0]   in_channels;
      logic [CNT_REG_W-1:0]   filter_count;
      logic [SMALL_REG_W-1:0] pad_width;
      logic [SMALL_REG_W-1:0] kernel_size;
   } cfg_type;

   // One tap issued to the MAC unit
   typedef struct packed {
      logic clear;
      logic valid;
      logic live;
   } tap_type;

   // Completion of a compute beat
   typedef struct packed {
      logic fire;
      logic err;
   } done_type;

endpackage

// ----- rtl/cmzp_if.sv -----
interface cmzp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cmzp_pkg::MODE_W-1:0]          mode;
   logic [cmzp_pkg::FILTER_W-1:0]        filter_index;
   logic [cmzp_pkg::CHANNEL_W-1:0]       channel;
   logic [cmzp_pkg::COORD_W-1:0]         row;
   logic [cmzp_pkg::COORD_W-1:0]         col;
   logic signed [cmzp_pkg::VALUE_W-1:0]  value;

   modport source (output valid, mode, filter_index, channel, row, col, value, input ready);
   modport sink (input valid, mode, filter_index, channel, row, col, value, output ready);
endinterface

interface cmzp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cmzp_pkg::FILTER_W-1:0]        out_filter;
   logic [cmzp_pkg::COORD_W-1:0]         out_row;
   logic [cmzp_pkg::COORD_W-1:0]         out_col;
   logic signed [cmzp_pkg::VALUE_W-1:0]  out_value;
   logic                                 range_error;

   modport source (output valid, out_filter, out_row, out_col, out_value, range_error,
                   input ready);
   modport sink (input valid, out_filter, out_row, out_col, out_value, range_error,
                 output ready);
endinterface

// ----- rtl/cmzp_store.sv -----
module cmzp_store #(
   parameter int MAX_DIM      = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_FILTERS  = 16,
   parameter int MAX_KERNEL   = 3
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic [cmzp_pkg::MODE_W-1:0]         mode,
   input  logic [cmzp_pkg::FILTER_W-1:0]       filter_index,
   input  logic [cmzp_pkg::CHANNEL_W-1:0]      channel,
   input  logic [cmzp_pkg::COORD_W-1:0]        row,
   input  logic [cmzp_pkg::COORD_W-1:0]        col,
   input  logic signed [cmzp_pkg::VALUE_W-1:0] value,
   input  logic [$clog2(MAX_DIM)*2+((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0]
                                               pix_raddr,
   input  logic [((MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1)
                 + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)
                 + 2*((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0]
                                               wgt_raddr,
   input  logic [((MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1)-1:0]
                                               bias_raddr,
   output logic signed [cmzp_pkg::VALUE_W-1:0] px_ff,
   output logic signed [cmzp_pkg::VALUE_W-1:0] wt_ff,
   output logic signed [cmzp_pkg::VALUE_W-1:0] bias_ff
);

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FLT_W  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int KW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PIX_AW = CH_W + 2*DIM_W;
   localparam int WGT_AW = FLT_W + CH_W + 2*KW;

   logic signed [cmzp_pkg::VALUE_W-1:0] pix_mem  [2**PIX_AW];
   logic signed [cmzp_pkg::VALUE_W-1:0] wgt_mem  [2**WGT_AW];
   logic signed [cmzp_pkg::VALUE_W-1:0] bias_mem [2**FLT_W];

   logic              pix_we;
   logic              wgt_we;
   logic              bias_we;
   logic [PIX_AW-1:0] pix_waddr;
   logic [WGT_AW-1:0] wgt_waddr;
   logic [FLT_W-1:0]  bias_waddr;
   logic              flt_ok;
   logic              ch_ok;

   // Decode load beats; drop those beyond the store bounds
   always_comb begin
      flt_ok     = 32'(filter_index) < MAX_FILTERS;
      ch_ok      = 32'(channel) < MAX_CHANNELS;
      pix_we     = load && (mode == cmzp_pkg::MODE_PIXEL) && ch_ok
                   && (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
      wgt_we     = load && (mode == cmzp_pkg::MODE_WEIGHT) && flt_ok && ch_ok
                   && (32'(row) < MAX_KERNEL) && (32'(col) < MAX_KERNEL);
      bias_we    = load && (mode == cmzp_pkg::MODE_BIAS) && flt_ok;
      pix_waddr  = {CH_W'(channel), DIM_W'(row), DIM_W'(col)};
      wgt_waddr  = {FLT_W'(filter_index), CH_W'(channel), KW'(row), KW'(col)};
      bias_waddr = FLT_W'(filter_index);
   end

   // Write ports
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_waddr] <= value;
      end
      if (wgt_we) begin
         wgt_mem[wgt_waddr] <= value;
      end
      if (bias_we) begin
         bias_mem[bias_waddr] <= value;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      px_ff   <= pix_mem[pix_raddr];
      wt_ff   <= wgt_mem[wgt_raddr];
      bias_ff <= bias_mem[bias_raddr];
   end

endmodule

// ----- rtl/cmzp_mac.sv -----
module cmzp_mac #(
   parameter int ACC_W = 41
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmzp_pkg::tap_type                   tap,
   input  logic signed [cmzp_pkg::VALUE_W-1:0] px,
   input  logic signed [cmzp_pkg::VALUE_W-1:0] wt,
   input  logic signed [cmzp_pkg::VALUE_W-1:0] bias,
   output logic signed [cmzp_pkg::VALUE_W-1:0] result
);

   localparam int PROD_W = 2*cmzp_pkg::VALUE_W;

   cmzp_pkg::tap_type         tap1_ff;
   logic                      prod_vld_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   bias_ext;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   quot;

   // Multiply the aligned pixel and weight; zero a tap off the image
   always_comb begin
      prod_in = tap1_ff.live ? PROD_W'(px * wt) : '0;
   end

   // Accumulate products; clear on a new compute beat
   always_comb begin
      if (tap.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap1_ff     <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         tap1_ff     <= tap;
         prod_vld_ff <= tap1_ff.valid;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Add the bias as Q16.16, floor to Q8.8 and saturate
   always_comb begin
      bias_ext = ACC_W'(bias);
      sum      = acc_ff + (bias_ext <<< 8);
      quot     = sum >>> 8;
      if (quot > ACC_W'(cmzp_pkg::VALUE_MAX)) begin
         result = cmzp_pkg::VALUE_W'(cmzp_pkg::VALUE_MAX);
      end else if (quot < ACC_W'(cmzp_pkg::VALUE_MIN)) begin
         result = cmzp_pkg::VALUE_W'(cmzp_pkg::VALUE_MIN);
      end else begin
         result = quot[cmzp_pkg::VALUE_W-1:0];
      end
   end

endmodule

// ----- rtl/cmzp_seq.sv -----
module cmzp_seq #(
   parameter int MAX_DIM      = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_FILTERS  = 16,
   parameter int MAX_KERNEL   = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmzp_pkg::cfg_type              cfg,
   input  logic                           start,
   input  logic [cmzp_pkg::FILTER_W-1:0]  item_filter,
   input  logic [cmzp_pkg::COORD_W-1:0]   item_row,
   input  logic [cmzp_pkg::COORD_W-1:0]   item_col,
   input  logic                           out_free,
   output logic                           idle,
   output cmzp_pkg::tap_type              tap,
   output cmzp_pkg::done_type             done,
   output logic [cmzp_pkg::FILTER_W-1:0]  f_ff,
   output logic [cmzp_pkg::COORD_W-1:0]   r_ff,
   output logic [cmzp_pkg::COORD_W-1:0]   c_ff,
   output logic [$clog2(MAX_DIM)*2+((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0]
                                          pix_raddr,
   output logic [((MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1)
                 + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)
                 + 2*((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0]
                                          wgt_raddr,
   output logic [((MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1)-1:0]
                                          bias_raddr
);

   localparam int DIM_W = $clog2(MAX_DIM);
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FLT_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int DCW   = $clog2(MAX_DIM + 1);
   localparam int NCW   = $clog2(MAX_CHANNELS + 1);
   localparam int NFW   = $clog2(MAX_FILTERS + 1);
   localparam int KCW   = $clog2(MAX_KERNEL + 1);
   localparam int SW    = ((DCW > cmzp_pkg::COORD_W) ? DCW : cmzp_pkg::COORD_W) + 3;

   cmzp_pkg::state_type state_ff;
   cmzp_pkg::state_type state_in;

   logic [DCW-1:0]                   dim_c;
   logic [NCW-1:0]                   nch_c;
   logic [NFW-1:0]                   nf_c;
   logic [cmzp_pkg::SMALL_REG_W-1:0] pad_c;
   logic [KCW-1:0]                   k_c;
   logic signed [SW-1:0]             dim_cs;
   logic signed [SW-1:0]             odim_s;
   logic signed [SW-1:0]             row_s;
   logic signed [SW-1:0]             col_s;
   logic                             err_in;

   logic                             err_ff;
   logic [DCW-1:0]                   dim_ff;
   logic [NCW-1:0]                   nch_ff;
   logic [KCW-1:0]                   k_ff;
   logic [cmzp_pkg::SMALL_REG_W-1:0] pad_ff;
   logic [CH_W-1:0]                  j_ff;
   logic [CH_W-1:0]                  j_in;
   logic [KW-1:0]                    kr_ff;
   logic [KW-1:0]                    kr_in;
   logic [KW-1:0]                    kc_ff;
   logic [KW-1:0]                    kc_in;
   logic [1:0]                       drain_ff;
   logic [1:0]                       drain_in;

   logic signed [SW-1:0]             ir;
   logic signed [SW-1:0]             ic;
   logic signed [SW-1:0]             dim_s;
   logic                             live;
   logic                             kc_end;
   logic                             kr_end;
   logic                             j_end;
   logic                             last;
   logic                             drain_end;

   // Clamp the registers at use and check the output area
   always_comb begin
      if (cfg.image_dim == '0) begin
         dim_c = DCW'(1);
      end else if (32'(cfg.image_dim) > MAX_DIM) begin
         dim_c = DCW'(MAX_DIM);
      end else begin
         dim_c = DCW'(cfg.image_dim);
      end
      if (cfg.in_channels == '0) begin
         nch_c = NCW'(1);
      end else if (32'(cfg.in_channels) > MAX_CHANNELS) begin
         nch_c = NCW'(MAX_CHANNELS);
      end else begin
         nch_c = NCW'(cfg.in_channels);
      end
      if (cfg.filter_count == '0) begin
         nf_c = NFW'(1);
      end else if (32'(cfg.filter_count) > MAX_FILTERS) begin
         nf_c = NFW'(MAX_FILTERS);
      end else begin
         nf_c = NFW'(cfg.filter_count);
      end
      if (cfg.kernel_size == '0) begin
         k_c = KCW'(1);
      end else if (32'(cfg.kernel_size) > MAX_KERNEL) begin
         k_c = KCW'(MAX_KERNEL);
      end else begin
         k_c = KCW'(cfg.kernel_size);
      end
      pad_c  = (cfg.pad_width > cmzp_pkg::PAD_MAX) ? cmzp_pkg::PAD_MAX : cfg.pad_width;
      dim_cs = SW'(dim_c);
      row_s  = SW'(item_row);
      col_s  = SW'(item_col);
      if (pad_c == '0) begin
         odim_s = dim_cs - SW'(k_c) + SW'(1);
      end else begin
         odim_s = dim_cs;
      end
      err_in = (32'(item_filter) >= 32'(nf_c)) || (odim_s <= 0)
               || (row_s >= odim_s) || (col_s >= odim_s);
   end

   // Tap coordinates, padding test and loop ends
   always_comb begin
      dim_s     = SW'(dim_ff);
      ir        = SW'(r_ff) + SW'(kr_ff) - SW'(pad_ff);
      ic        = SW'(c_ff) + SW'(kc_ff) - SW'(pad_ff);
      live      = (ir >= 0) && (ir < dim_s) && (ic >= 0) && (ic < dim_s);
      kc_end    = (32'(kc_ff) + 32'd1) == 32'(k_ff);
      kr_end    = (32'(kr_ff) + 32'd1) == 32'(k_ff);
      j_end     = (32'(j_ff) + 32'd1) == 32'(nch_ff);
      last      = kc_end && kr_end && j_end;
      drain_end = drain_ff == 2'(cmzp_pkg::DRAIN_CYCLES - 1);
      pix_raddr  = {j_ff, ir[DIM_W-1:0], ic[DIM_W-1:0]};
      wgt_raddr  = {FLT_W'(f_ff), j_ff, kr_ff, kc_ff};
      bias_raddr = FLT_W'(f_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmzp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = err_in ? cmzp_pkg::ST_FINAL : cmzp_pkg::ST_ISSUE;
            end
         end
         cmzp_pkg::ST_ISSUE: begin
            if (last) begin
               state_in = cmzp_pkg::ST_DRAIN;
            end
         end
         cmzp_pkg::ST_DRAIN: begin
            if (drain_end) begin
               state_in = cmzp_pkg::ST_FINAL;
            end
         end
         cmzp_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = cmzp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmzp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      idle       = state_ff == cmzp_pkg::ST_IDLE;
      tap.clear  = start;
      tap.valid  = state_ff == cmzp_pkg::ST_ISSUE;
      tap.live   = live;
      done.fire  = (state_ff == cmzp_pkg::ST_FINAL) && out_free;
      done.err   = err_ff;
   end

   // Advance the channel and kernel counters
   always_comb begin
      j_in     = j_ff;
      kr_in    = kr_ff;
      kc_in    = kc_ff;
      drain_in = '0;
      if (start) begin
         j_in  = '0;
         kr_in = '0;
         kc_in = '0;
      end else if (state_ff == cmzp_pkg::ST_ISSUE) begin
         if (!kc_end) begin
            kc_in = kc_ff + KW'(1);
         end else begin
            kc_in = '0;
            if (!kr_end) begin
               kr_in = kr_ff + KW'(1);
            end else begin
               kr_in = '0;
               j_in  = j_ff + CH_W'(1);
            end
         end
      end
      if (state_ff == cmzp_pkg::ST_DRAIN) begin
         drain_in = drain_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmzp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      j_ff     <= j_in;
      kr_ff    <= kr_in;
      kc_ff    <= kc_in;
      drain_ff <= drain_in;
      if (start) begin
         f_ff   <= item_filter;
         r_ff   <= item_row;
         c_ff   <= item_col;
         err_ff <= err_in;
         dim_ff <= dim_c;
         nch_ff <= nch_c;
         k_ff   <= k_c;
         pad_ff <= pad_c;
      end
   end

endmodule

// ----- rtl/multichannel_conv2d_zero_pad.sv -----
// Load beats (pixel, weight, bias) are taken back to back while idle and return nothing.
// A compute beat runs one tap per cycle through a single shared MAC unit;
// its result loads the response register once the taps drain and that register is free,
// and no new beat is taken until then; a range error skips the taps and the drain.
// Synchronous active-high reset clears the sequencer, the response register
// and restores the CSRs to their defaults; the stores keep their contents.
module multichannel_conv2d_zero_pad #(
   parameter int MAX_DIM      = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int MAX_FILTERS  = 16,
   parameter int MAX_KERNEL   = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cmzp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cmzp_pkg::CSR_DATA_W-1:0]     csr_data,
   cmzp_req_if.sink                            req_bus,
   cmzp_rsp_if.source                          rsp_bus
);

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FLT_W  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int KW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PIX_AW = CH_W + 2*DIM_W;
   localparam int WGT_AW = FLT_W + CH_W + 2*KW;
   localparam int TAPS   = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int ACC_W  = 2*cmzp_pkg::VALUE_W + $clog2(TAPS + 1) + 1;

   cmzp_pkg::cfg_type  cfg_ff;
   cmzp_pkg::cfg_type  cfg_in;
   cmzp_pkg::tap_type  tap;
   cmzp_pkg::done_type done;

   logic                                accept;
   logic                                start;
   logic                                load;
   logic                                idle;
   logic                                out_free;
   logic [cmzp_pkg::FILTER_W-1:0]       f_ff;
   logic [cmzp_pkg::COORD_W-1:0]        r_ff;
   logic [cmzp_pkg::COORD_W-1:0]        c_ff;
   logic [PIX_AW-1:0]                   pix_raddr;
   logic [WGT_AW-1:0]                   wgt_raddr;
   logic [FLT_W-1:0]                    bias_raddr;
   logic signed [cmzp_pkg::VALUE_W-1:0] px;
   logic signed [cmzp_pkg::VALUE_W-1:0] wt;
   logic signed [cmzp_pkg::VALUE_W-1:0] bias;
   logic signed [cmzp_pkg::VALUE_W-1:0] mac_result;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [cmzp_pkg::FILTER_W-1:0]       rsp_filter_ff;
   logic [cmzp_pkg::COORD_W-1:0]        rsp_row_ff;
   logic [cmzp_pkg::COORD_W-1:0]        rsp_col_ff;
   logic signed [cmzp_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                                rsp_err_ff;

   // CSR writes; indexes past the register list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cmzp_pkg::REG_IMAGE_DIM: begin
               cfg_in.image_dim = csr_data[cmzp_pkg::DIM_REG_W-1:0];
            end
            cmzp_pkg::REG_IN_CHANNELS: begin
               cfg_in.in_channels = csr_data[cmzp_pkg::CNT_REG_W-1:0];
            end
            cmzp_pkg::REG_FILTER_COUNT: begin
               cfg_in.filter_count = csr_data[cmzp_pkg::CNT_REG_W-1:0];
            end
            cmzp_pkg::REG_PAD_WIDTH: begin
               cfg_in.pad_width = csr_data[cmzp_pkg::SMALL_REG_W-1:0];
            end
            cmzp_pkg::REG_KERNEL_SIZE: begin
               cfg_in.kernel_size = csr_data[cmzp_pkg::SMALL_REG_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_dim    <= cmzp_pkg::IMAGE_DIM_RST;
         cfg_ff.in_channels  <= cmzp_pkg::IN_CHANNELS_RST;
         cfg_ff.filter_count <= cmzp_pkg::FILTER_COUNT_RST;
         cfg_ff.pad_width    <= cmzp_pkg::PAD_WIDTH_RST;
         cfg_ff.kernel_size  <= cmzp_pkg::KERNEL_SIZE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request handshake: take beats whenever the sequencer is idle
   always_comb begin
      req_bus.ready = idle;
      accept        = req_bus.valid && idle;
      start         = accept && (req_bus.mode == cmzp_pkg::MODE_COMPUTE);
      load          = accept && (req_bus.mode != cmzp_pkg::MODE_COMPUTE);
      out_free      = !rsp_valid_ff || rsp_bus.ready;
   end

   cmzp_seq #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_FILTERS  (MAX_FILTERS),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .item_filter (req_bus.filter_index),
      .item_row    (req_bus.row),
      .item_col    (req_bus.col),
      .out_free    (out_free),
      .idle        (idle),
      .tap         (tap),
      .done        (done),
      .f_ff        (f_ff),
      .r_ff        (r_ff),
      .c_ff        (c_ff),
      .pix_raddr   (pix_raddr),
      .wgt_raddr   (wgt_raddr),
      .bias_raddr  (bias_raddr)
   );

   cmzp_store #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_FILTERS  (MAX_FILTERS),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_store (
      .clock        (clock),
      .load         (load),
      .mode         (req_bus.mode),
      .filter_index (req_bus.filter_index),
      .channel      (req_bus.channel),
      .row          (req_bus.row),
      .col          (req_bus.col),
      .value        (req_bus.value),
      .pix_raddr    (pix_raddr),
      .wgt_raddr    (wgt_raddr),
      .bias_raddr   (bias_raddr),
      .px_ff        (px),
      .wt_ff        (wt),
      .bias_ff      (bias)
   );

   cmzp_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .tap    (tap),
      .px     (px),
      .wt     (wt),
      .bias   (bias),
      .result (mac_result)
   );

   // Response register: load on completion, drop on a taken beat
   always_comb begin
      if (done.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done.fire) begin
         rsp_filter_ff <= f_ff;
         rsp_row_ff    <= r_ff;
         rsp_col_ff    <= c_ff;
         rsp_value_ff  <= done.err ? '0 : mac_result;
         rsp_err_ff    <= done.err;
      end
   end

   always_comb begin
      rsp_bus.valid       = rsp_valid_ff;
      rsp_bus.out_filter  = rsp_filter_ff;
      rsp_bus.out_row     = rsp_row_ff;
      rsp_bus.out_col     = rsp_col_ff;
      rsp_bus.out_value   = rsp_value_ff;
      rsp_bus.range_error = rsp_err_ff;
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;

   localparam int MAX_DIM       = 64;
   localparam int MAX_CHANNELS  = 16;
   localparam int MAX_FILTERS   = 16;
   localparam int MAX_KERNEL    = 3;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 160;
   localparam int ITEM_TARGET   = 1550;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int REPORT_LIMIT  = 10;

   // Short local names for the package widths
   localparam int FILTER_W    = cmzp_pkg::FILTER_W;
   localparam int CHANNEL_W   = cmzp_pkg::CHANNEL_W;
   localparam int COORD_W     = cmzp_pkg::COORD_W;
   localparam int VALUE_W     = cmzp_pkg::VALUE_W;
   localparam int DIM_REG_W   = cmzp_pkg::DIM_REG_W;
   localparam int CNT_REG_W   = cmzp_pkg::CNT_REG_W;
   localparam int SMALL_REG_W = cmzp_pkg::SMALL_REG_W;
   localparam int CSR_INDEX_W = cmzp_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = cmzp_pkg::CSR_DATA_W;

   typedef struct {
      cmzp_pkg::mode_type          mode;
      logic [FILTER_W-1:0]         filt;
      logic [CHANNEL_W-1:0]        chan;
      logic [COORD_W-1:0]          row;
      logic [COORD_W-1:0]          col;
      logic signed [VALUE_W-1:0]   value;
   } conv_beat_type;

   typedef struct {
      logic [FILTER_W-1:0]         filt;
      logic [COORD_W-1:0]          row;
      logic [COORD_W-1:0]          col;
      logic signed [VALUE_W-1:0]   value;
      logic                        err;
   } conv_output_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   cmzp_req_if req_bus ();
   cmzp_rsp_if rsp_bus ();

   multichannel_conv2d_zero_pad dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Shadow copies of the stores, with a mark for every entry written
   logic signed [VALUE_W-1:0] pixel_copy  [MAX_CHANNELS][MAX_DIM][MAX_DIM];
   bit                        pixel_known [MAX_CHANNELS][MAX_DIM][MAX_DIM];
   logic signed [VALUE_W-1:0] weight_copy [MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
   bit                        weight_known[MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
   logic signed [VALUE_W-1:0] bias_copy   [MAX_FILTERS];
   bit                        bias_known  [MAX_FILTERS];

   // Register values as the datapath uses them (masked and saturated)
   int eff_dim      = int'(cmzp_pkg::IMAGE_DIM_RST);
   int eff_channels = int'(cmzp_pkg::IN_CHANNELS_RST);
   int eff_filters  = int'(cmzp_pkg::FILTER_COUNT_RST);
   int eff_pad      = int'(cmzp_pkg::PAD_WIDTH_RST);
   int eff_kernel   = int'(cmzp_pkg::KERNEL_SIZE_RST);

   conv_output_type outputs_due[$];

   int  beats_taken       = 0;
   int  computes_sent     = 0;
   int  outputs_checked   = 0;
   int  range_errors_seen = 0;
   int  phases_run        = 0;
   int  mismatch_count    = 0;
   int  cycle_count       = 0;
   int  rsp_hold          = 0;
   bit  req_idle          = 1'b1;
   bit  rsp_idle          = 1'b1;

   // Clock and run limit
   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d outputs outstanding",
                  cycle_count, outputs_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int clamp_to(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int draw_wait(bit enabled);
      return enabled ? int'($urandom_range(0, 17)) : 0;
   endfunction

   function automatic int output_side();
      return (eff_pad == 0) ? eff_dim - eff_kernel + 1 : eff_dim;
   endfunction

   // Expected output of one compute beat
   function automatic conv_output_type convolve(conv_beat_type b);
      conv_output_type o;
      int              odim;
      int              ir;
      int              ic;
      longint          acc;
      odim    = output_side();
      o.filt  = b.filt;
      o.row   = b.row;
      o.col   = b.col;
      o.value = '0;
      o.err   = (int'(b.filt) >= eff_filters) || (odim <= 0) ||
                (int'(b.row) >= odim) || (int'(b.col) >= odim);
      if (!o.err) begin
         acc = 0;
         for (int j = 0; j < eff_channels; j++) begin
            for (int kr = 0; kr < eff_kernel; kr++) begin
               ir = int'(b.row) + kr - eff_pad;
               if (ir < 0 || ir >= eff_dim) continue;
               for (int kc = 0; kc < eff_kernel; kc++) begin
                  ic = int'(b.col) + kc - eff_pad;
                  if (ic < 0 || ic >= eff_dim) continue;
                  acc += longint'(pixel_copy[j][ir][ic]) *
                         longint'(weight_copy[b.filt][j][kr][kc]);
               end
            end
         end
         acc += longint'(bias_copy[b.filt]) * 256;
         // Round toward minus infinity, then saturate
         acc = acc >>> 8;
         if (acc > cmzp_pkg::VALUE_MAX) acc = cmzp_pkg::VALUE_MAX;
         if (acc < cmzp_pkg::VALUE_MIN) acc = cmzp_pkg::VALUE_MIN;
         o.value = acc[VALUE_W-1:0];
      end
      return o;
   endfunction

   // Update the shadow stores for an accepted beat; return 0 if the block drops it
   function automatic bit absorb_beat(conv_beat_type b);
      case (b.mode)
         cmzp_pkg::MODE_PIXEL: begin
            pixel_copy[b.chan][b.row][b.col]  = b.value;
            pixel_known[b.chan][b.row][b.col] = 1'b1;
            return 1'b1;
         end
         cmzp_pkg::MODE_WEIGHT: begin
            if (b.row < MAX_KERNEL && b.col < MAX_KERNEL) begin
               weight_copy[b.filt][b.chan][b.row][b.col]  = b.value;
               weight_known[b.filt][b.chan][b.row][b.col] = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         cmzp_pkg::MODE_BIAS: begin
            bias_copy[b.filt]  = b.value;
            bias_known[b.filt] = 1'b1;
            return 1'b1;
         end
         default: begin
            outputs_due.push_back(convolve(b));
            computes_sent++;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic conv_beat_type make_beat(cmzp_pkg::mode_type m, int f, int ch, int r,
                                               int c, logic signed [VALUE_W-1:0] v);
      conv_beat_type b;
      b.mode  = m;
      b.filt  = f[FILTER_W-1:0];
      b.chan  = ch[CHANNEL_W-1:0];
      b.row   = r[COORD_W-1:0];
      b.col   = c[COORD_W-1:0];
      b.value = v;
      return b;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return -16'sd1;
         3:       return 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly near the corners of a large output so loaded pixels get reused
   function automatic int pick_coord(int odim);
      int v;
      if (odim > 6 && $urandom_range(0, 9) < 6) begin
         v = $urandom_range(0, 5);
         return (v < 3) ? v : odim - 6 + v;
      end
      return $urandom_range(0, odim - 1);
   endfunction

   // Drive one beat after a random gap and hold it until the block takes it
   task automatic send_beat(conv_beat_type b);
      int gap;
      gap = draw_wait(req_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= b.mode;
      req_bus.filter_index <= b.filt;
      req_bus.channel      <= b.chan;
      req_bus.row          <= b.row;
      req_bus.col          <= b.col;
      req_bus.value        <= b.value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      if (absorb_beat(b)) beats_taken++;
   endtask

   // Hold off until every expected output has come back
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers back to back; only call while the block is idle
   task automatic apply_config(logic [DIM_REG_W-1:0] dim, logic [CNT_REG_W-1:0] nch,
                               logic [CNT_REG_W-1:0] nf, logic [SMALL_REG_W-1:0] pad,
                               logic [SMALL_REG_W-1:0] k);
      csr_we    <= 1'b1;
      csr_index <= cmzp_pkg::REG_IMAGE_DIM;
      csr_data  <= CSR_DATA_W'(dim);
      @(posedge clock);
      csr_index <= cmzp_pkg::REG_IN_CHANNELS;
      csr_data  <= CSR_DATA_W'(nch);
      @(posedge clock);
      csr_index <= cmzp_pkg::REG_FILTER_COUNT;
      csr_data  <= CSR_DATA_W'(nf);
      @(posedge clock);
      csr_index <= cmzp_pkg::REG_PAD_WIDTH;
      csr_data  <= CSR_DATA_W'(pad);
      @(posedge clock);
      csr_index <= cmzp_pkg::REG_KERNEL_SIZE;
      csr_data  <= CSR_DATA_W'(k);
      @(posedge clock);
      csr_we <= 1'b0;
      eff_dim      = clamp_to(int'(dim), 1, MAX_DIM);
      eff_channels = clamp_to(int'(nch), 1, MAX_CHANNELS);
      eff_filters  = clamp_to(int'(nf), 1, MAX_FILTERS);
      eff_pad      = clamp_to(int'(pad), 0, int'(cmzp_pkg::PAD_MAX));
      eff_kernel   = clamp_to(int'(k), 1, MAX_KERNEL);
   endtask

   // Load whatever the output window still lacks, then send the compute beat
   task automatic issue_compute(int f, int r, int c);
      int odim;
      int ir;
      int ic;
      odim = output_side();
      if (f < eff_filters && r < odim && c < odim) begin
         for (int j = 0; j < eff_channels; j++) begin
            for (int kr = 0; kr < eff_kernel; kr++) begin
               ir = r + kr - eff_pad;
               if (ir < 0 || ir >= eff_dim) continue;
               for (int kc = 0; kc < eff_kernel; kc++) begin
                  ic = c + kc - eff_pad;
                  if (ic < 0 || ic >= eff_dim) continue;
                  if (!pixel_known[j][ir][ic])
                     send_beat(make_beat(cmzp_pkg::MODE_PIXEL, $urandom, j, ir, ic,
                                         pick_value()));
                  if (!weight_known[f][j][kr][kc])
                     send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, f, j, kr, kc, pick_value()));
               end
            end
         end
         if (!bias_known[f])
            send_beat(make_beat(cmzp_pkg::MODE_BIAS, f, $urandom, $urandom, $urandom,
                                pick_value()));
      end
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, f, $urandom, r, c, 16'($urandom)));
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endtask

   // Receive side: compare each output beat with the oldest expectation
   task automatic check_output();
      conv_output_type want;
      if (outputs_due.size() == 0) begin
         report_mismatch($sformatf("unexpected output filter %0d row %0d col %0d value %0d",
                                   rsp_bus.out_filter, rsp_bus.out_row, rsp_bus.out_col,
                                   rsp_bus.out_value));
         return;
      end
      want = outputs_due.pop_front();
      outputs_checked++;
      if (want.err) range_errors_seen++;
      if (rsp_bus.out_filter !== want.filt || rsp_bus.out_row !== want.row ||
          rsp_bus.out_col !== want.col || rsp_bus.out_value !== want.value ||
          rsp_bus.range_error !== want.err)
         report_mismatch($sformatf(
            "expected f%0d r%0d c%0d v%0d err%0b, got f%0d r%0d c%0d v%0d err%0b",
            want.filt, want.row, want.col, want.value, want.err,
            rsp_bus.out_filter, rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value,
            rsp_bus.range_error));
   endtask

   // Check each beat, then stall ready for a random gap while stalls are on
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready && !reset) begin
         check_output();
         if ($urandom_range(0, 29) == 0) rsp_idle = !rsp_idle;
         rsp_hold = draw_wait(rsp_idle);
         rsp_bus.ready <= (rsp_hold == 0);
      end else if (rsp_bus.ready !== 1'b1) begin
         if (rsp_hold > 0) rsp_hold--;
         if (rsp_hold == 0) rsp_bus.ready <= 1'b1;
      end
   end

   // Full-scale operands drive both saturation bounds; floor rounding on a negative sum
   task automatic test_saturation_and_rounding();
      wait_quiet();
      apply_config(2, 1, 2, 0, 1);
      send_beat(make_beat(cmzp_pkg::MODE_PIXEL, 0, 0, 0, 0, 16'sh7FFF));
      send_beat(make_beat(cmzp_pkg::MODE_PIXEL, 0, 0, 0, 1, -16'sd1));
      send_beat(make_beat(cmzp_pkg::MODE_PIXEL, 0, 0, 1, 0, 16'sh8000));
      send_beat(make_beat(cmzp_pkg::MODE_PIXEL, 0, 0, 1, 1, 16'sd1));
      send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, 0, 0, 0, 0, 16'sh7FFF));
      send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, 1, 0, 0, 0, 16'sh8000));
      send_beat(make_beat(cmzp_pkg::MODE_BIAS, 0, 0, 0, 0, 16'sh7FFF));
      send_beat(make_beat(cmzp_pkg::MODE_BIAS, 1, 0, 0, 0, 16'sh8000));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 1, 0, 0, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 1, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 1, 0, 1, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 0, 1, 0));
      send_beat(make_beat(cmzp_pkg::MODE_BIAS, 0, 0, 0, 0, 16'sd0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 0, 1, 0));
   endtask

   // Filter, row and column each past the output area
   task automatic test_range_errors();
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 2, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 0, 2, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 2, 0, 0, 0, 0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 15, 15, 63, 63, 16'shFFFF));
   endtask

   // Weight loads past the kernel store must leave it untouched
   task automatic test_ignored_loads();
      send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, 0, 0, 3, 0, 16'sd0));
      send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, 0, 0, 0, 63, 16'sd0));
      send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, 15, 15, 63, 63, 16'sd0));
      send_beat(make_beat(cmzp_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0));
   endtask

   // Kernel wider than the image with padding on, and a kernel larger than the image in valid mode
   task automatic test_padding_edges();
      wait_quiet();
      apply_config(1, 2, 1, 2, 3);
      issue_compute(0, 0, 0);
      issue_compute(0, 1, 0);
      wait_quiet();
      apply_config(2, 1, 1, 0, 3);
      issue_compute(0, 0, 0);
      wait_quiet();
      apply_config(2, 1, 1, 1, 3);
      issue_compute(0, 1, 1);
   endtask

   // Out-of-range register values saturate at both ends
   task automatic test_register_clamping();
      wait_quiet();
      apply_config(0, 0, 0, 3, 0);
      issue_compute(0, 0, 0);
      issue_compute(0, 0, 1);
      wait_quiet();
      apply_config(127, 31, 31, 0, 3);
      issue_compute(15, 61, 61);
      issue_compute(15, 62, 0);
      issue_compute(15, 0, 0);
   endtask

   // Random configurations, each followed by a stream of loads and computes
   task automatic test_random_phases();
      int dim;
      int nch;
      int nf;
      int odim;
      int steps;
      int pick;
      while (beats_taken < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       dim = MAX_DIM;
            1:       dim = $urandom_range(0, 1) ? $urandom_range(65, 127) : 0;
            default: dim = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0:       nch = MAX_CHANNELS;
            1:       nch = $urandom_range(0, 1) ? $urandom_range(17, 31) : 0;
            default: nch = $urandom_range(1, 3);
         endcase
         nf = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(0, 31);
         wait_quiet();
         apply_config(DIM_REG_W'(dim), CNT_REG_W'(nch), CNT_REG_W'(nf),
                      SMALL_REG_W'($urandom_range(0, 3)), SMALL_REG_W'($urandom_range(0, 3)));
         phases_run++;
         req_idle = ($urandom_range(0, 2) != 0);
         odim  = output_side();
         steps = $urandom_range(40, 120);
         for (int s = 0; s < steps && beats_taken < ITEM_TARGET; s++) begin
            if ($urandom_range(0, 49) == 0) req_idle = !req_idle;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               if (odim > 0)
                  issue_compute($urandom_range(0, eff_filters - 1), pick_coord(odim),
                                pick_coord(odim));
               else
                  issue_compute($urandom_range(0, 15), $urandom_range(0, 63),
                                $urandom_range(0, 63));
            end else if (pick < 55) begin
               issue_compute($urandom_range(0, 15), $urandom_range(0, 63),
                             $urandom_range(0, 63));
            end else if (pick < 75) begin
               if ($urandom_range(0, 1))
                  send_beat(make_beat(cmzp_pkg::MODE_PIXEL, $urandom,
                                      $urandom_range(0, eff_channels - 1),
                                      $urandom_range(0, eff_dim - 1),
                                      $urandom_range(0, eff_dim - 1), pick_value()));
               else
                  send_beat(make_beat(cmzp_pkg::MODE_PIXEL, $urandom, $urandom, $urandom,
                                      $urandom, pick_value()));
            end else if (pick < 87) begin
               if ($urandom_range(0, 4) != 0)
                  send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, $urandom_range(0, eff_filters - 1),
                                      $urandom_range(0, eff_channels - 1),
                                      $urandom_range(0, 2), $urandom_range(0, 2), pick_value()));
               else
                  send_beat(make_beat(cmzp_pkg::MODE_WEIGHT, $urandom, $urandom, $urandom,
                                      $urandom, pick_value()));
            end else if (pick < 95) begin
               send_beat(make_beat(cmzp_pkg::MODE_BIAS, $urandom, $urandom, $urandom, $urandom,
                                   pick_value()));
            end else begin
               wait_quiet();
            end
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = cmzp_pkg::REG_IMAGE_DIM;
      csr_data             = '0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = cmzp_pkg::MODE_PIXEL;
      req_bus.filter_index = '0;
      req_bus.channel      = '0;
      req_bus.row          = '0;
      req_bus.col          = '0;
      req_bus.value        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_saturation_and_rounding();
      test_range_errors();
      test_ignored_loads();
      test_padding_edges();
      test_register_clamping();
      test_random_phases();

      // Drain, then give the block time to emit anything stray
      req_bus.valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d beats over %0d random register settings plus directed cases;",
               beats_taken, phases_run);
      $display("%0d outputs checked (%0d range errors), %0d mismatches.",
               outputs_checked, range_errors_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- multichannel_conv2d_zero_pad.f -----
rtl/cmzp_pkg.sv
rtl/cmzp_if.sv
rtl/cmzp_store.sv
rtl/cmzp_mac.sv
rtl/cmzp_seq.sv
rtl/multichannel_conv2d_zero_pad.sv
verif/testbench.sv
